/* sv/ubsp_pkg.sv */
// Shared types, constants and the reciprocal table of the uniform B-spline evaluator.
// Used by the channel interfaces, the multiply-add unit and the top level.
package ubsp_pkg;

  // Sizes of the block
  localparam int MAX_POINTS  = 128;
  localparam int MAX_ORDER   = 9;
  localparam int COORD_BITS  = 12;
  localparam int T_FRAC_BITS = 8;
  localparam int ALPHA_FRAC  = 16;

  // Field and register widths
  localparam int PIDX_W  = $clog2(MAX_POINTS);
  localparam int T_W     = 15;
  localparam int SPAN_W  = T_W - T_FRAC_BITS;
  localparam int ORDER_W = 4;
  localparam int COUNT_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int STATUS_W   = 2;

  // Internal widths
  localparam int WORK_W  = COORD_BITS + ALPHA_FRAC;   // work coordinate, 16 fraction bits
  localparam int WIDX_W  = $clog2(MAX_ORDER);         // work memory address
  localparam int NUM_W   = ORDER_W + ALPHA_FRAC;      // alpha numerator (distance << 8)
  localparam int RECIP_SHIFT = 22;                    // exact for numerators below 2^19
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int OPA_W   = WORK_W + 2;
  localparam int OPB_W   = RECIP_W + 1;
  localparam int PROD_W  = OPA_W + OPB_W;

  // Opcodes and register indexes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_INDEX = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_PREP,
    S_ALPHA,
    S_MULX,
    S_MULY,
    S_DONE
  } ubsp_state_e;

  typedef enum logic {
    MAC_ALPHA,
    MAC_BLEND
  } mac_mode_e;

  typedef struct packed {
    logic                  opcode;
    logic [PIDX_W-1:0]     point_index;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic [T_W-1:0]        param_t;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] curve_x;
    logic [COORD_BITS-1:0] curve_y;
    logic [STATUS_W-1:0]   status;
  } out_item_t;

  // Request to the shared multiply-add unit
  typedef struct packed {
    mac_mode_e             mode;
    logic [ORDER_W-1:0]    dist_int;   // whole knots between t and the knot
    logic [T_FRAC_BITS-1:0] frac;      // fraction of t
    logic [ORDER_W-1:0]    divisor;    // order - pass
    logic [WORK_W-1:0]     hi;
    logic [WORK_W-1:0]     lo;
    logic [ALPHA_FRAC-1:0] alpha;
  } mac_req_t;

  // ceil(2^22 / d) for the divisors that occur
  function automatic logic [RECIP_W-1:0] recip(input logic [ORDER_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd1:    r = 23'd4194304;
      4'd2:    r = 23'd2097152;
      4'd3:    r = 23'd1398102;
      4'd4:    r = 23'd1048576;
      4'd5:    r = 23'd838861;
      4'd6:    r = 23'd699051;
      4'd7:    r = 23'd599187;
      4'd8:    r = 23'd524288;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/ubsp_if.sv */
// Valid/ready channel interfaces for evaluator commands and results.
// Depends on ubsp_pkg for the payload types.
interface ubsp_in_if;
  import ubsp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ubsp_out_if;
  import ubsp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/uniform_bspline_deboor_eval.sv */
// Top level of the uniform B-spline evaluator: control point memory, sequencer, work points.
// Depends on ubsp_pkg, ubsp_if and ubsp_mac.
//
// A load transaction writes one control point and returns its status through the output
// register. An evaluate transaction copies the order k points of its span into a small work
// memory and runs the de Boor passes through a single multiplier that is used three times
// per blend (alpha by reciprocal, then x, then y). The input is not ready while an item is
// in work; a finished result waits in the output register without blocking the next item.
// No clearing pass follows reset: a control point must be loaded before any evaluate reads it.
module uniform_bspline_deboor_eval (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ubsp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ubsp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  ubsp_in_if.sink                             in_if,
  ubsp_out_if.source                          out_if
);
  import ubsp_pkg::*;

  // Configuration
  logic [ORDER_W-1:0] order_q;
  logic [COUNT_W-1:0] count_q;

  // Sequencer
  ubsp_state_e state_q, state_d;
  logic [ORDER_W-1:0] k_q;
  logic [ORDER_W-1:0] lc_q;
  logic [ORDER_W-1:0] r_q;
  logic [ORDER_W-1:0] m_q;
  logic               first_q;

  // Datapath
  logic [PIDX_W-1:0]      base_q;
  logic [T_FRAC_BITS-1:0] frac_q;
  logic [2*WORK_W-1:0]    hi_q;
  logic [2*WORK_W-1:0]    lo_q;
  logic [ALPHA_FRAC-1:0]  alpha_q;
  logic [WORK_W-1:0]      newx_q;
  logic [COORD_BITS-1:0]  res_x_q;
  logic [COORD_BITS-1:0]  res_y_q;
  logic [STATUS_W-1:0]    res_st_q;
  logic                   out_valid_q;
  out_item_t              out_data_q;

  // Memories
  logic [2*COORD_BITS-1:0] ctrl_mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] ctrl_rd_q;
  logic [2*WORK_W-1:0]     work_mem [MAX_ORDER];
  logic [2*WORK_W-1:0]     wk_rd_q;

  // Combinational control
  logic                    accept;
  logic                    out_free;
  logic                    ctrl_we;
  logic                    ctrl_re;
  logic [PIDX_W-1:0]       ctrl_raddr;
  logic                    wk_we;
  logic [WIDX_W-1:0]       wk_waddr;
  logic [2*WORK_W-1:0]     wk_wdata;
  logic                    wk_re;
  logic [WIDX_W-1:0]       wk_raddr;
  mac_req_t                mac_req;
  logic [WORK_W-1:0]       mac_res;

  // Range checks of an evaluate
  logic [SPAN_W-1:0]  span;
  logic [COUNT_W-1:0] n_eff;
  logic [COUNT_W-1:0] k_ext;
  logic               eval_err;
  logic               idx_ok;
  status_e            acc_status;

  assign span  = in_if.data.param_t[T_W-1:T_FRAC_BITS];
  assign n_eff = (count_q > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : count_q;
  assign k_ext = COUNT_W'(order_q);
  assign idx_ok = 32'(in_if.data.point_index) < MAX_POINTS;

  always_comb begin
    eval_err = 1'b0;
    if (order_q == '0 || 32'(order_q) > MAX_ORDER || n_eff < k_ext) begin
      eval_err = 1'b1;
    end else if (COUNT_W'(span) < k_ext - 1'b1 || COUNT_W'(span) >= n_eff) begin
      eval_err = 1'b1;
    end
  end

  always_comb begin
    if (in_if.data.opcode == OP_LOAD) begin
      acc_status = idx_ok ? ST_OK : ST_INDEX;
    end else begin
      acc_status = eval_err ? ST_RANGE : ST_OK;
    end
  end

  assign in_if.ready = (state_q == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_q || out_if.ready;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_if.data.opcode == OP_EVAL && !eval_err) begin
            state_d = S_LOAD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_LOAD: begin
        if (lc_q == k_q) begin
          state_d = (k_q == ORDER_W'(1)) ? S_DONE : S_PREP;
        end
      end
      S_PREP:  state_d = S_ALPHA;
      S_ALPHA: state_d = S_MULX;
      S_MULX:  state_d = S_MULY;
      S_MULY: begin
        if (m_q > r_q) begin
          state_d = S_ALPHA;
        end else if (r_q + 1'b1 < k_q) begin
          state_d = S_PREP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory strobes and multiplier requests
  always_comb begin
    ctrl_we    = accept && in_if.data.opcode == OP_LOAD && idx_ok;
    ctrl_re    = 1'b0;
    ctrl_raddr = base_q + PIDX_W'(lc_q);
    wk_we      = 1'b0;
    wk_waddr   = '0;
    wk_wdata   = '0;
    wk_re      = 1'b0;
    wk_raddr   = '0;

    mac_req.mode     = MAC_BLEND;
    mac_req.dist_int = k_q - 1'b1 - m_q;
    mac_req.frac     = frac_q;
    mac_req.divisor  = k_q - r_q;
    mac_req.hi       = hi_q[2*WORK_W-1:WORK_W];
    mac_req.lo       = wk_rd_q[2*WORK_W-1:WORK_W];
    mac_req.alpha    = alpha_q;

    case (state_q)
      S_LOAD: begin
        ctrl_re  = lc_q < k_q;
        wk_we    = lc_q != '0;
        wk_waddr = WIDX_W'(lc_q - 1'b1);
        wk_wdata = {ctrl_rd_q[2*COORD_BITS-1:COORD_BITS], ALPHA_FRAC'(0),
                    ctrl_rd_q[COORD_BITS-1:0], ALPHA_FRAC'(0)};
      end
      S_PREP: begin
        wk_re    = 1'b1;
        wk_raddr = WIDX_W'(k_q - 1'b1);
      end
      S_ALPHA: begin
        wk_re        = 1'b1;
        wk_raddr     = WIDX_W'(m_q - 1'b1);
        mac_req.mode = MAC_ALPHA;
      end
      S_MULY: begin
        mac_req.hi = hi_q[WORK_W-1:0];
        mac_req.lo = lo_q[WORK_W-1:0];
        wk_we      = 1'b1;
        wk_waddr   = WIDX_W'(m_q);
        wk_wdata   = {newx_q, mac_res};
      end
      default: begin
      end
    endcase
  end

  ubsp_mac u_mac (
    .req_i (mac_req),
    .res_o (mac_res)
  );

  // Control point memory
  always_ff @(posedge clk_i) begin
    if (ctrl_we) begin
      ctrl_mem[in_if.data.point_index] <= {in_if.data.point_x, in_if.data.point_y};
    end
    if (ctrl_re) begin
      ctrl_rd_q <= ctrl_mem[ctrl_raddr];
    end
  end

  // Work point memory
  always_ff @(posedge clk_i) begin
    if (wk_we) begin
      work_mem[wk_waddr] <= wk_wdata;
    end
    if (wk_re) begin
      wk_rd_q <= work_mem[wk_raddr];
    end
  end

  // Configuration, state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= ORDER_W'(4);
      count_q     <= '0;
      state_q     <= S_IDLE;
      lc_q        <= '0;
      r_q         <= '0;
      m_q         <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ORDER: order_q <= cfg_data_i[ORDER_W-1:0];
          CFG_COUNT: count_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // Load a new result when done, drop the result once taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          lc_q <= '0;
        end
        S_LOAD: begin
          lc_q <= lc_q + 1'b1;
          if (lc_q == k_q) begin
            r_q     <= ORDER_W'(1);
            m_q     <= k_q - 1'b1;
            first_q <= 1'b1;
          end
        end
        S_MULY: begin
          if (m_q > r_q) begin
            m_q     <= m_q - 1'b1;
            first_q <= 1'b0;
          end else begin
            r_q     <= r_q + 1'b1;
            m_q     <= k_q - 1'b1;
            first_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          k_q      <= order_q;
          base_q   <= PIDX_W'(span - SPAN_W'(order_q - 1'b1));
          frac_q   <= in_if.data.param_t[T_FRAC_BITS-1:0];
          res_x_q  <= '0;
          res_y_q  <= '0;
          res_st_q <= acc_status;
        end
      end
      S_LOAD: begin
        if (lc_q != '0 && lc_q == k_q) begin
          res_x_q <= ctrl_rd_q[2*COORD_BITS-1:COORD_BITS];
          res_y_q <= ctrl_rd_q[COORD_BITS-1:0];
        end
      end
      S_ALPHA: begin
        alpha_q <= mac_res[ALPHA_FRAC-1:0];
        if (first_q) begin
          hi_q <= wk_rd_q;
        end
      end
      S_MULX: begin
        lo_q   <= wk_rd_q;
        newx_q <= mac_res;
      end
      S_MULY: begin
        hi_q <= lo_q;
        if (m_q == k_q - 1'b1) begin
          res_x_q <= newx_q[WORK_W-1:ALPHA_FRAC];
          res_y_q <= mac_res[WORK_W-1:ALPHA_FRAC];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data_q.curve_x <= res_x_q;
          out_data_q.curve_y <= res_y_q;
          out_data_q.status  <= res_st_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/ubsp_mac.sv */
// Shared multiply-add unit: computes alpha by reciprocal multiply, or one linear blend.
// Depends on ubsp_pkg for the request struct and the reciprocal table.
module ubsp_mac (
  input  ubsp_pkg::mac_req_t             req_i,
  output logic [ubsp_pkg::WORK_W-1:0]    res_o
);
  import ubsp_pkg::*;

  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [WORK_W:0]   diff;
  logic [ALPHA_FRAC-1:0]    alpha;

  // Select operands for the one multiplier
  always_comb begin
    diff = signed'({1'b0, req_i.hi}) - signed'({1'b0, req_i.lo});
    if (req_i.mode == MAC_ALPHA) begin
      op_a = signed'(OPA_W'({req_i.dist_int, req_i.frac,
                             (ALPHA_FRAC - T_FRAC_BITS)'(0)}));
      op_b = signed'({1'b0, recip(req_i.divisor)});
    end else begin
      op_a = OPA_W'(diff);
      op_b = signed'(OPB_W'(req_i.alpha));
    end
  end

  assign prod = op_a * op_b;

  // Quotient, saturated just below one
  always_comb begin
    if (prod[PROD_W-1:RECIP_SHIFT+ALPHA_FRAC] != '0) begin
      alpha = '1;
    end else begin
      alpha = prod[RECIP_SHIFT+ALPHA_FRAC-1:RECIP_SHIFT];
    end
  end

  // lo + (alpha * (hi - lo)) >> 16, floored
  always_comb begin
    if (req_i.mode == MAC_ALPHA) begin
      res_o = WORK_W'(alpha);
    end else begin
      res_o = req_i.lo + prod[WORK_W+ALPHA_FRAC-1:ALPHA_FRAC];
    end
  end

endmodule

/* tb/sv/tb_uniform_bspline_deboor_eval.sv */
// Self-checking testbench of the uniform B-spline evaluator (de Boor on integer knots).
// Depends on ubsp_pkg and ubsp_if; drives directed rows, then random phases, checked by a predictor.
module tb_uniform_bspline_deboor_eval;
  import ubsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 12;
  localparam int STALL_LIMIT = 5000;
  localparam int EVAL_CYCLES = 140;

  localparam out_item_t RES_NONE  = '0;
  localparam out_item_t RES_LOAD  = '{curve_x: '0, curve_y: '0, status: ST_OK};
  localparam out_item_t RES_RANGE = '{curve_x: '0, curve_y: '0, status: ST_RANGE};
  localparam out_item_t RES_FULL  = '{curve_x: 12'hFFF, curve_y: 12'hFFF, status: ST_OK};

  typedef enum logic {ROW_WRITE_REG, ROW_COMMAND} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              cmd;
    bit                    typed;
    out_item_t             want;
  } dir_row_t;

  typedef struct {
    int order_val;
    int count_val;
    int n_cmds;
  } phase_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ubsp_in_if  cmd_if ();
  ubsp_out_if res_if ();

  uniform_bspline_deboor_eval i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (cmd_if),
    .out_if     (res_if)
  );

  // Shadow of the block: registers and control point memory
  logic [ORDER_W-1:0]    spl_order;
  logic [COUNT_W-1:0]    spl_count;
  logic [COORD_BITS-1:0] pt_x [MAX_POINTS];
  logic [COORD_BITS-1:0] pt_y [MAX_POINTS];
  bit                    pt_loaded [MAX_POINTS];

  out_item_t pending_points [$];
  dir_row_t  dir_rows [$];
  phase_t    phases [$];

  int errors;
  int results_seen;
  int burst_left;
  int n_loads;
  int n_eval_ok;
  int n_eval_range;
  int n_settings;

  // Receiver pattern state
  int hold_left;
  int next_hold;
  int mode;
  int mode_left;
  bit toggle;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int active_points();
    return (int'(spl_count) > MAX_POINTS) ? MAX_POINTS : int'(spl_count);
  endfunction

  // True when an evaluate at t passes the order, count and range checks
  function automatic bit span_valid(input logic [T_W-1:0] t);
    int k;
    int n;
    k = int'(spl_order);
    n = active_points();
    if (k < 1 || k > MAX_ORDER || n < k) return 1'b0;
    return (int'(t) >= ((k - 1) << T_FRAC_BITS)) && (int'(t) < (n << T_FRAC_BITS));
  endfunction

  // First control point of the span at t that was never loaded, or -1
  function automatic int first_unloaded(input logic [T_W-1:0] t);
    int k;
    int j;
    k = int'(spl_order);
    if (!span_valid(t)) return -1;
    j = int'(t) >> T_FRAC_BITS;
    for (int i = j - k + 1; i <= j; i++) begin
      if (!pt_loaded[i]) return i;
    end
    return -1;
  endfunction

  // Expected result of one command; a load updates the shadow memory
  function automatic out_item_t deboor_point(input in_item_t c);
    out_item_t         res;
    longint unsigned   wx [MAX_ORDER];
    longint unsigned   wy [MAX_ORDER];
    longint unsigned   t;
    longint unsigned   d;
    longint unsigned   a;
    int                k;
    int                j;
    int                base;
    res = RES_LOAD;
    if (c.opcode == OP_LOAD) begin
      if (int'(c.point_index) >= MAX_POINTS) begin
        res.status = ST_INDEX;
      end else begin
        pt_x[c.point_index]      = c.point_x;
        pt_y[c.point_index]      = c.point_y;
        pt_loaded[c.point_index] = 1'b1;
      end
    end else if (!span_valid(c.param_t)) begin
      res = RES_RANGE;
    end else begin
      k    = int'(spl_order);
      t    = longint'(c.param_t);
      j    = int'(c.param_t) >> T_FRAC_BITS;
      base = j - (k - 1);
      for (int m = 0; m < k; m++) begin
        wx[m] = longint'(pt_x[base + m]) << ALPHA_FRAC;
        wy[m] = longint'(pt_y[base + m]) << ALPHA_FRAC;
      end
      // de Boor passes, top point first so lower points are still the old ones
      for (int r = 1; r < k; r++) begin
        for (int m = k - 1; m >= r; m--) begin
          d = t - (longint'(j) << T_FRAC_BITS) + (longint'(k - 1 - m) << T_FRAC_BITS);
          a = (d << ALPHA_FRAC) / (longint'(k - r) << T_FRAC_BITS);
          if (a >= (64'd1 << ALPHA_FRAC)) a = (64'd1 << ALPHA_FRAC) - 1;
          wx[m] = (a * wx[m] + ((64'd1 << ALPHA_FRAC) - a) * wx[m - 1]) >> ALPHA_FRAC;
          wy[m] = (a * wy[m] + ((64'd1 << ALPHA_FRAC) - a) * wy[m - 1]) >> ALPHA_FRAC;
        end
      end
      res.curve_x = COORD_BITS'(wx[k - 1] >> ALPHA_FRAC);
      res.curve_y = COORD_BITS'(wy[k - 1] >> ALPHA_FRAC);
      res.status  = ST_OK;
    end
    return res;
  endfunction

  function automatic in_item_t mk_cmd(input logic op, input int idx, input int x, input int y,
                                      input int t);
    in_item_t c;
    c.opcode      = op;
    c.point_index = PIDX_W'(idx);
    c.point_x     = COORD_BITS'(x);
    c.point_y     = COORD_BITS'(y);
    c.param_t     = T_W'(t);
    return c;
  endfunction

  function automatic void add_reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    dir_row_t row;
    row.kind    = ROW_WRITE_REG;
    row.reg_idx = idx;
    row.reg_val = CFG_DATA_W'(val);
    row.cmd     = '0;
    row.typed   = 1'b0;
    row.want    = RES_NONE;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cmd_row(input in_item_t c, input bit typed, input out_item_t want);
    dir_row_t row;
    row.kind    = ROW_COMMAND;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.cmd     = c;
    row.typed   = typed;
    row.want    = want;
    dir_rows.push_back(row);
  endfunction

  // Random command: mostly in-range evaluates, loads biased into the active points
  function automatic in_item_t random_cmd();
    in_item_t c;
    int       k;
    int       n;
    int       lo;
    int       hi;
    k = int'(spl_order);
    n = active_points();
    c = mk_cmd(OP_EVAL, $urandom_range(0, MAX_POINTS - 1), $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom_range(0, 32767));
    if ($urandom_range(0, 9) < 3) begin
      c.opcode = OP_LOAD;
      if (n > 0 && $urandom_range(0, 1) == 1) c.point_index = PIDX_W'($urandom_range(0, n - 1));
    end else if (k >= 1 && k <= MAX_ORDER && $urandom_range(0, 99) < 85) begin
      lo = (k - 1) << T_FRAC_BITS;
      hi = (((n << T_FRAC_BITS) > 32768) ? 32768 : (n << T_FRAC_BITS)) - 1;
      if (lo <= hi) c.param_t = T_W'($urandom_range(lo, hi));
    end
    return c;
  endfunction

  // Offer one transaction in bursts with random gaps; predict it on acceptance
  task automatic send_cmd(input in_item_t c, input bit typed, input out_item_t want);
    out_item_t predicted;
    int        gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        cmd_if.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    cmd_if.valid = 1'b1;
    cmd_if.data  = c;
    do @(posedge clk); while (!cmd_if.ready);
    predicted = deboor_point(c);
    pending_points.push_back(typed ? want : predicted);
    if (c.opcode == OP_LOAD) n_loads++;
    else if (predicted.status == ST_OK) n_eval_ok++;
    else n_eval_range++;
  endtask

  // Hold the input, wait for every expected result, then let the block go quiet
  task automatic settle(input int quiet_cycles);
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (quiet_cycles) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we   = 1'b0;
    if (idx == CFG_ORDER) spl_order = ORDER_W'(val);
    else spl_count = COUNT_W'(val);
    n_settings++;
  endtask

  // Receiver: stall pattern changes at random, with long hold-offs now and then
  initial begin
    res_if.ready = 1'b0;
    hold_left    = 0;
    next_hold    = 150;
    mode         = 0;
    mode_left    = 0;
    toggle       = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && results_seen >= next_hold) begin
        hold_left = 400;
        next_hold += 450;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      toggle = ~toggle;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready = 1'b0;
      end else begin
        case (mode)
          0:       res_if.ready = 1'b1;
          1:       res_if.ready = 1'($urandom_range(0, 1));
          2:       res_if.ready = ($urandom_range(0, 3) == 0);
          default: res_if.ready = toggle;
        endcase
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  initial begin
    out_item_t want;
    out_item_t got;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        results_seen++;
        if (pending_points.size() == 0) begin
          errors++;
          $display("%0t: unexpected result x=%0d y=%0d status=%0d", $time, got.curve_x,
                   got.curve_y, got.status);
        end else begin
          want = pending_points.pop_front();
          if (got.curve_x !== want.curve_x || got.curve_y !== want.curve_y ||
              got.status !== want.status) begin
            errors++;
            $display("%0t: mismatch expected x=%0d y=%0d status=%0d, actual x=%0d y=%0d status=%0d",
                     $time, want.curve_x, want.curve_y, want.status, got.curve_x, got.curve_y,
                     got.status);
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    in_item_t c;
    phase_t   ph;
    int       miss;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    spl_order    = ORDER_W'(4);
    spl_count    = '0;
    errors       = 0;
    results_seen = 0;
    burst_left   = 0;
    n_loads      = 0;
    n_eval_ok    = 0;
    n_eval_range = 0;
    n_settings   = 0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      pt_x[i]      = '0;
      pt_y[i]      = '0;
      pt_loaded[i] = 1'b0;
    end

    // Directed rows: reset values, full-scale points, range edges, bad orders
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 0), 1'b1, RES_RANGE);
    for (int i = 0; i < 4; i++) add_cmd_row(mk_cmd(OP_LOAD, i, 4095, 4095, 0), 1'b1, RES_LOAD);
    add_cmd_row(mk_cmd(OP_LOAD, 4, 0, 0, 0), 1'b1, RES_LOAD);
    add_cmd_row(mk_cmd(OP_LOAD, 127, 4095, 0, 0), 1'b1, RES_LOAD);
    add_cmd_row(mk_cmd(OP_LOAD, 126, 0, 4095, 0), 1'b1, RES_LOAD);
    add_cmd_row(mk_cmd(OP_LOAD, 125, 4095, 4095, 0), 1'b1, RES_LOAD);
    add_cmd_row(mk_cmd(OP_LOAD, 124, 0, 0, 0), 1'b1, RES_LOAD);
    add_reg_row(CFG_COUNT, 128);
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 768), 1'b1, RES_FULL);
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 1023), 1'b1, RES_FULL);
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 767), 1'b1, RES_RANGE);
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 32767), 1'b0, RES_NONE);
    add_reg_row(CFG_COUNT, 4);
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 1024), 1'b1, RES_RANGE);
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 1023), 1'b1, RES_FULL);
    add_reg_row(CFG_ORDER, 1);
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 4), 1'b1, RES_FULL);
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 0), 1'b1, RES_FULL);
    add_reg_row(CFG_ORDER, 9);
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 1023), 1'b1, RES_RANGE);
    add_reg_row(CFG_ORDER, 0);
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 512), 1'b1, RES_RANGE);
    add_reg_row(CFG_ORDER, 15);
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 512), 1'b1, RES_RANGE);
    add_reg_row(CFG_ORDER, 2);
    add_reg_row(CFG_COUNT, 5);
    add_cmd_row(mk_cmd(OP_EVAL, 0, 0, 0, 1152), 1'b0, RES_NONE);

    // Random phases: order, point count, number of commands
    phases = '{'{4, 128, 150}, '{9, 128, 150}, '{1, 128, 80}, '{2, 50, 80}, '{3, 9, 60},
               '{9, 9, 60}, '{5, 255, 100}, '{0, 128, 20}, '{15, 100, 20}, '{8, 200, 100},
               '{9, 0, 20}};
    for (int i = 0; i < 3; i++) phases.push_back('{$urandom_range(1, 9), $urandom_range(0, 255), 80});

    // Reset
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE_REG) begin
        settle(EVAL_CYCLES);
        set_reg(dir_rows[i].reg_idx, int'(dir_rows[i].reg_val));
      end else begin
        send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random part
    foreach (phases[p]) begin
      ph = phases[p];
      settle(EVAL_CYCLES);
      set_reg(CFG_ORDER, ph.order_val);
      set_reg(CFG_COUNT, ph.count_val);
      for (int i = 0; i < ph.n_cmds; i++) begin
        // now and then drain completely before going on
        if ($urandom_range(0, 99) == 0) settle(0);
        c = random_cmd();
        // never read a point that was never loaded: load it instead
        if (c.opcode == OP_EVAL) begin
          miss = first_unloaded(c.param_t);
          if (miss >= 0) begin
            c.opcode      = OP_LOAD;
            c.point_index = PIDX_W'(miss);
          end
        end
        send_cmd(c, 1'b0, RES_NONE);
      end
    end

    settle(EVAL_CYCLES + 10);
    $display("Run covered %0d loads and %0d evaluates (%0d in range, %0d rejected)",
             n_loads, n_eval_ok + n_eval_range, n_eval_ok, n_eval_range);
    $display("over %0d register writes, %0d results checked", n_settings, results_seen);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* uniform_bspline_deboor_eval.f */
sv/ubsp_pkg.sv
sv/ubsp_if.sv
sv/ubsp_mac.sv
sv/uniform_bspline_deboor_eval.sv
tb/sv/tb_uniform_bspline_deboor_eval.sv
